@@ rtl/kfs_pkg.sv @@
package kfs_pkg;

    localparam int COORD_W = 32;              // Q16.16 coordinate width
    localparam int CFG_W   = 16;              // configuration data width
    localparam int CIDX_W  = 3;               // configuration index width
    localparam int FRAME_W = 16;
    localparam int U_FRAC  = 16;              // u in Q0.16
    localparam int U_W     = U_FRAC + 1;      // holds 0..65536
    localparam int WGT_W   = 36;              // basis weight, Q.31 signed
    localparam int WLO_W   = 18;              // low split of a weight
    localparam int WHI_W   = WGT_W - WLO_W;
    localparam int OUT_SH  = 31;              // Q.31 weights back to Q16.16

    typedef enum logic [CIDX_W-1:0] {
        CFG_TENSION   = 3'd0,
        CFG_CUR_FRAME = 3'd1,
        CFG_SEG_START = 3'd2,
        CFG_SEG_END   = 3'd3,
        CFG_LAST      = 3'd4,
        CFG_SPACING   = 3'd5
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t p0_x;
        coord_t p0_y;
        coord_t p0_z;
        coord_t p1_x;
        coord_t p1_y;
        coord_t p1_z;
        coord_t p2_x;
        coord_t p2_y;
        coord_t p2_z;
        coord_t p3_x;
        coord_t p3_y;
        coord_t p3_z;
    } vertex_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
    } point_t;

    // basis weights and end clamps, shared by all lanes
    typedef struct packed {
        logic [3:0][WGT_W-1:0] w;
        logic                  first_seg;
        logic                  last_seg;
    } coef_t;

endpackage

@@ rtl/kfs_weight_gen.sv @@
module kfs_weight_gen (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kfs_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [kfs_pkg::CFG_W-1:0]      cfg_data,
    output kfs_pkg::coef_t                 coef,
    output logic                           busy
);

    localparam int FW = kfs_pkg::FRAME_W;
    localparam int UW = kfs_pkg::U_W;
    localparam int UF = kfs_pkg::U_FRAC;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_SQR  = 6'b001000,
        ST_CUBE = 6'b010000,
        ST_WGT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [kfs_pkg::CFG_W-1:0] tension_reg;
    logic [FW-1:0] cur_reg, start_reg, end_reg, last_reg, spacing_reg;

    logic [FW-1:0] rem_reg, rem_next;
    logic [FW-1:0] den_reg, den_next;
    logic [UF-1:0] q_reg, q_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [UW-1:0] u_reg, u_next;
    logic [UW-1:0] u2_reg, u2_next;
    logic [UW-1:0] u3_reg, u3_next;
    kfs_pkg::coef_t coef_reg, coef_next;

    logic [FW:0]       trial;
    logic              ge;
    logic [2*UW-1:0]   sq, cu;

    logic signed [39:0] s_v, u_v, u2_v, u3_v, a0, a3, w0, w1, w2, w3;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= '0;
            cur_reg     <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            last_reg    <= FW'(20);
            spacing_reg <= FW'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kfs_pkg::CFG_TENSION:   tension_reg <= $signed(cfg_data);
                kfs_pkg::CFG_CUR_FRAME: cur_reg     <= cfg_data;
                kfs_pkg::CFG_SEG_START: start_reg   <= cfg_data;
                kfs_pkg::CFG_SEG_END:   end_reg     <= cfg_data;
                kfs_pkg::CFG_LAST:      last_reg    <= cfg_data;
                kfs_pkg::CFG_SPACING:   spacing_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // restoring divide step
    assign trial = {rem_reg, 1'b0};
    assign ge    = trial >= {1'b0, den_reg};

    assign sq = (2*UW)'(u_reg) * (2*UW)'(u_reg);
    assign cu = (2*UW)'(u2_reg) * (2*UW)'(u_reg);

    // S = (1 - tension)/2 in Q.15 (tension in Q.14), weights in Q.31
    always_comb
    begin
        s_v  = 40'sd16384 - 40'(tension_reg);
        u_v  = $signed(40'(u_reg));
        u2_v = $signed(40'(u2_reg));
        u3_v = $signed(40'(u3_reg));
        a0   = -u_v + 40'sd2 * u2_v - u3_v;
        a3   = u3_v - u2_v;
        w0   = s_v * a0;
        w1   = (40'sd1 <<< 31) + (s_v - 40'sd98304) * u2_v + (40'sd65536 - s_v) * u3_v;
        w2   = s_v * u_v + (40'sd98304 - 40'sd2 * s_v) * u2_v + (s_v - 40'sd65536) * u3_v;
        w3   = s_v * a3;
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        u_next     = u_reg;
        u2_next    = u2_reg;
        u3_next    = u3_reg;
        coef_next  = coef_reg;
        case (state_reg)
            ST_IDLE: ;
            ST_LOAD:
            begin
                if (end_reg <= start_reg || cur_reg <= start_reg)
                begin
                    u_next     = '0;
                    state_next = ST_SQR;
                end
                else if (cur_reg >= end_reg)
                begin
                    u_next     = UW'(1) << UF;
                    state_next = ST_SQR;
                end
                else
                begin
                    rem_next   = cur_reg - start_reg;
                    den_next   = end_reg - start_reg;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? FW'(trial - {1'b0, den_reg}) : trial[FW-1:0];
                q_next   = {q_reg[UF-2:0], ge};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    u_next     = {1'b0, q_next};
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                u2_next    = sq[UF+UW-1:UF];
                state_next = ST_CUBE;
            end
            ST_CUBE:
            begin
                u3_next    = cu[UF+UW-1:UF];
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                coef_next.w[0]    = w0[kfs_pkg::WGT_W-1:0];
                coef_next.w[1]    = w1[kfs_pkg::WGT_W-1:0];
                coef_next.w[2]    = w2[kfs_pkg::WGT_W-1:0];
                coef_next.w[3]    = w3[kfs_pkg::WGT_W-1:0];
                coef_next.first_seg = cur_reg < spacing_reg;
                coef_next.last_seg  = !(cur_reg < spacing_reg) &&
                    (({1'b0, cur_reg} + {1'b0, spacing_reg}) > {1'b0, last_reg});
                state_next = ST_IDLE;
            end
            default: state_next = ST_LOAD;
        endcase
        // any write restarts the weight computation
        if (cfg_we)
        begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        u_reg    <= u_next;
        u2_reg   <= u2_next;
        u3_reg   <= u3_next;
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;
    assign busy = state_reg != ST_IDLE;

endmodule

@@ rtl/kfs_lane.sv @@
module kfs_lane (
    input  logic            clk,
    input  kfs_pkg::coord_t p0,
    input  kfs_pkg::coord_t p1,
    input  kfs_pkg::coord_t p2,
    input  kfs_pkg::coord_t p3,
    input  kfs_pkg::coef_t  coef,
    output kfs_pkg::coord_t result
);

    localparam int CW   = kfs_pkg::COORD_W;
    localparam int PL_W = CW + kfs_pkg::WLO_W + 1;
    localparam int PH_W = CW + kfs_pkg::WHI_W;
    localparam int AW   = CW + kfs_pkg::WGT_W + 2;
    localparam int RW   = AW - kfs_pkg::OUT_SH;
    localparam logic signed [AW-1:0] ROUND = AW'(1) <<< (kfs_pkg::OUT_SH - 1);

    kfs_pkg::coord_t          pa_reg [4];
    logic signed [PL_W-1:0]   pl_reg [4];
    logic signed [PH_W-1:0]   ph_reg [4];
    logic signed [AW-1:0]     acc_reg, acc_sum;
    logic signed [RW-1:0]     shifted;
    kfs_pkg::coord_t          result_reg, sat;

    // stage A: end clamping
    always_ff @(posedge clk)
    begin
        pa_reg[0] <= coef.first_seg ? p1 : p0;
        pa_reg[1] <= p1;
        pa_reg[2] <= p2;
        pa_reg[3] <= coef.last_seg ? p2 : p3;
    end

    // stage B: split partial products
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            pl_reg[k] <= PL_W'(pa_reg[k]) *
                PL_W'($signed({1'b0, coef.w[k][kfs_pkg::WLO_W-1:0]}));
            ph_reg[k] <= PH_W'(pa_reg[k]) *
                PH_W'($signed(coef.w[k][kfs_pkg::WGT_W-1:kfs_pkg::WLO_W]));
        end
    end

    // stage C: sum plus half
    always_comb
    begin
        acc_sum = ROUND;
        for (int k = 0; k < 4; k++)
        begin
            acc_sum = acc_sum + (AW'(ph_reg[k]) <<< kfs_pkg::WLO_W) + AW'(pl_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_sum;
    end

    // stage D: floor and saturate
    assign shifted = acc_reg[AW-1:kfs_pkg::OUT_SH];

    always_comb
    begin
        if (shifted[RW-1:CW-1] == '0 || shifted[RW-1:CW-1] == '1)
        begin
            sat = shifted[CW-1:0];
        end
        else if (shifted[RW-1])
        begin
            sat = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= sat;
    end

    assign result = result_reg;

endmodule

@@ rtl/keyframe_spline_interpolator_unit.sv @@
// Cardinal spline interpolator, one vertex per word.
//
// Input channel: a vertex word (four keyframe points, x/y/z each, Q16.16) is
// taken at a clock edge where start is high and busy is low. One result word
// (out_x/out_y/out_z, rounded and saturated Q16.16) appears on point with
// valid high for exactly one cycle, tracked by a shift register beside the
// lane stages. Throughput is one word per clock while busy is low: three
// identical lanes (x, y, z) each run a four-stage pipeline: end clamp, split
// partial products, sum, saturate.
//
// Config port: cfg_we/cfg_index/cfg_data write one register per edge. Every
// write makes the weight generator recompute u and the four basis weights:
// a load step, a bit-serial divide for u, a square step, a cube step and a
// weight step. The divide runs only when the frame lies inside the segment;
// otherwise u is clamped to 0 or 1. busy is high while the recompute runs.
//
// Reset: registers take their defaults and the same recompute runs (u is 0),
// so busy is high after reset until it is done. The result side cannot stall,
// so nothing is ever held back or dropped.
module keyframe_spline_interpolator_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  kfs_pkg::vertex_t           vertex,
    output logic                       valid,
    output kfs_pkg::point_t            point,
    input  logic                       cfg_we,
    input  logic [kfs_pkg::CIDX_W-1:0] cfg_index,
    input  logic [kfs_pkg::CFG_W-1:0]  cfg_data
);

    kfs_pkg::coef_t  coef;
    kfs_pkg::coord_t rx, ry, rz;
    logic [3:0]      vld_reg;

    kfs_weight_gen u_wgen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .busy      (busy)
    );

    kfs_lane u_lane_x (
        .clk    (clk),
        .p0     (vertex.p0_x),
        .p1     (vertex.p1_x),
        .p2     (vertex.p2_x),
        .p3     (vertex.p3_x),
        .coef   (coef),
        .result (rx)
    );

    kfs_lane u_lane_y (
        .clk    (clk),
        .p0     (vertex.p0_y),
        .p1     (vertex.p1_y),
        .p2     (vertex.p2_y),
        .p3     (vertex.p3_y),
        .coef   (coef),
        .result (ry)
    );

    kfs_lane u_lane_z (
        .clk    (clk),
        .p0     (vertex.p0_z),
        .p1     (vertex.p1_z),
        .p2     (vertex.p2_z),
        .p3     (vertex.p3_z),
        .coef   (coef),
        .result (rz)
    );

    // valid tracks the four lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start & ~busy};
        end
    end

    // merge the lanes into one result word
    assign valid       = vld_reg[3];
    assign point.out_x = rx;
    assign point.out_y = ry;
    assign point.out_z = rz;

endmodule

@@ verif/keyframe_spline_interpolator_unit_tb.sv @@
module keyframe_spline_interpolator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles without any accepted or result word
    localparam int DRAIN_CYCLES   = 40;     // enough for pipeline depth plus a weight recompute

    // Scoreboard: predicts the interpolated point for each accepted vertex word
    // and checks the result words in order.
    class spline_scoreboard;
        int                 mismatches;
        kfs_pkg::point_t    expected_points[$];
        logic signed [15:0] tension_q14;
        logic [15:0]        cur_frame;
        logic [15:0]        seg_start;
        logic [15:0]        seg_end;
        logic [15:0]        last_frame;
        logic [15:0]        spacing;

        function new();
            mismatches = 0;
            tension_q14 = 16'sd0;
            cur_frame = 16'd0;
            seg_start = 16'd0;
            seg_end = 16'd0;
            last_frame = 16'd20;
            spacing = 16'd5;
        endfunction

        function void write_reg(kfs_pkg::cfg_idx_t idx, logic [15:0] data);
            case (idx)
                kfs_pkg::CFG_TENSION:   tension_q14 = data;
                kfs_pkg::CFG_CUR_FRAME: cur_frame = data;
                kfs_pkg::CFG_SEG_START: seg_start = data;
                kfs_pkg::CFG_SEG_END:   seg_end = data;
                kfs_pkg::CFG_LAST:      last_frame = data;
                kfs_pkg::CFG_SPACING:   spacing = data;
                default:       ;
            endcase
        endfunction

        // floor division by 2^n on a signed value
        function longint floor_sh(longint v, int n);
            return v >>> n;
        endfunction

        function kfs_pkg::coord_t blend_lane(kfs_pkg::coord_t c0, kfs_pkg::coord_t c1,
                                             kfs_pkg::coord_t c2, kfs_pkg::coord_t c3,
                                             longint wt[4], bit first_seg, bit last_seg);
            longint pts[4];
            longint hi, lo, ph, r;
            pts[0] = first_seg ? c1 : c0;
            pts[1] = c1;
            pts[2] = c2;
            pts[3] = last_seg ? c2 : c3;
            hi = 0;
            lo = 64'sd1 << 30;
            for (int k = 0; k < 4; k++)
            begin
                ph = floor_sh(pts[k], 24);
                hi += ph * wt[k];
                lo += (pts[k] - (ph <<< 24)) * wt[k];
            end
            r = floor_sh(hi + floor_sh(lo, 24), 7);
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return kfs_pkg::coord_t'(r);
        endfunction

        function void note_vertex(kfs_pkg::vertex_t v);
            longint s_q15, u, u2, u3;
            longint wt[4];
            bit first_seg, last_seg;
            kfs_pkg::point_t pt;
            s_q15 = 16384 - longint'(tension_q14);
            u = 0;
            if (seg_end > seg_start)
            begin
                if (cur_frame <= seg_start)
                    u = 0;
                else if (cur_frame >= seg_end)
                    u = 65536;
                else
                    u = (longint'(cur_frame - seg_start) << 16) / longint'(seg_end - seg_start);
            end
            u2 = (u * u) >> 16;
            u3 = (u2 * u) >> 16;
            wt[0] = s_q15 * (-u + 2 * u2 - u3);
            wt[1] = (64'sd1 << 31) + (s_q15 - 3 * 32768) * u2 + (2 * 32768 - s_q15) * u3;
            wt[2] = s_q15 * u + (3 * 32768 - 2 * s_q15) * u2 + (s_q15 - 2 * 32768) * u3;
            wt[3] = s_q15 * (u3 - u2);
            first_seg = cur_frame < spacing;
            last_seg = !first_seg &&
                       (longint'(cur_frame) > longint'(last_frame) - longint'(spacing));
            pt.out_x = blend_lane(v.p0_x, v.p1_x, v.p2_x, v.p3_x, wt, first_seg, last_seg);
            pt.out_y = blend_lane(v.p0_y, v.p1_y, v.p2_y, v.p3_y, wt, first_seg, last_seg);
            pt.out_z = blend_lane(v.p0_z, v.p1_z, v.p2_z, v.p3_z, wt, first_seg, last_seg);
            expected_points.insert(expected_points.size(), pt);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_point(kfs_pkg::point_t got);
            kfs_pkg::point_t want;
            if (expected_points.size() == 0)
            begin
                report("unexpected result word", got.out_x, 32'h0);
                return;
            end
            want = expected_points.pop_front();
            if (got.out_x !== want.out_x)
                report("out_x", got.out_x, want.out_x);
            if (got.out_y !== want.out_y)
                report("out_y", got.out_y, want.out_y);
            if (got.out_z !== want.out_z)
                report("out_z", got.out_z, want.out_z);
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    kfs_pkg::vertex_t              vertex;
    logic                          valid;
    kfs_pkg::point_t               point;
    logic                          cfg_we;
    logic [kfs_pkg::CIDX_W-1:0]    cfg_index;
    logic [kfs_pkg::CFG_W-1:0]     cfg_data;

    spline_scoreboard      board;
    int                    idle_cycles;

    keyframe_spline_interpolator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vertex    (vertex),
        .valid     (valid),
        .point     (point),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: every strobed word is checked at the edge that ends it.
    // The watchdog counts edges where neither side moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid)
                board.check_point(point);
            if ((start && !busy) || valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic kfs_pkg::coord_t pick_coord();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sh0;
            3:       return kfs_pkg::coord_t'($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
            default: return kfs_pkg::coord_t'($urandom());
        endcase
    endfunction

    function automatic kfs_pkg::vertex_t pick_vertex();
        kfs_pkg::vertex_t v;
        v.p0_x = pick_coord(); v.p0_y = pick_coord(); v.p0_z = pick_coord();
        v.p1_x = pick_coord(); v.p1_y = pick_coord(); v.p1_z = pick_coord();
        v.p2_x = pick_coord(); v.p2_y = pick_coord(); v.p2_z = pick_coord();
        v.p3_x = pick_coord(); v.p3_y = pick_coord(); v.p3_z = pick_coord();
        return v;
    endfunction

    // Register write, driven on the falling edge and sampled at a rising edge; the caller drops
    // the write enable after the last write.
    task write_cfg(kfs_pkg::cfg_idx_t idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Register writes only with the pipeline empty; start drops first.
    task wait_drained();
        start <= 1'b0;
        while (board.expected_points.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Sends one vertex word; with allow_gap set, a random gap may come first.
    // start stays high across back-to-back words.
    task send_vertex(kfs_pkg::vertex_t v, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 13) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        vertex <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_vertex(v);
        @(negedge clk);
    endtask

    task set_frames(logic [15:0] t, logic [15:0] cf, logic [15:0] ss, logic [15:0] se,
                    logic [15:0] lf, logic [15:0] sp);
        wait_drained();
        write_cfg(kfs_pkg::CFG_TENSION, t);
        write_cfg(kfs_pkg::CFG_CUR_FRAME, cf);
        write_cfg(kfs_pkg::CFG_SEG_START, ss);
        write_cfg(kfs_pkg::CFG_SEG_END, se);
        write_cfg(kfs_pkg::CFG_LAST, lf);
        write_cfg(kfs_pkg::CFG_SPACING, sp);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        kfs_pkg::vertex_t v;
        int      frame;
        board = new();
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        vertex = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: degenerate segment, first segment
        v = {12{32'sh7fffffff}};
        send_vertex(v, 1'b0);
        v = {12{32'sh80000000}};
        send_vertex(v, 1'b0);

        // mid segment, Catmull-Rom, alternating extremes saturate
        set_frames(16'h0000, 16'd12, 16'd10, 16'd15, 16'd40, 16'd5);
        v = {32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        send_vertex(v, 1'b0);
        send_vertex(~v, 1'b0);
        send_vertex(pick_vertex(), 1'b0);

        // extreme tensions, last segment then first segment
        set_frames(16'h8000, 16'd38, 16'd35, 16'd40, 16'd40, 16'd5);
        send_vertex(v, 1'b0);
        send_vertex(pick_vertex(), 1'b0);
        set_frames(16'h7fff, 16'd1, 16'd0, 16'd3, 16'd65535, 16'd65535);
        send_vertex(v, 1'b0);
        send_vertex(pick_vertex(), 1'b0);

        // frame before, after segment; zero spacing; widest segment
        set_frames(16'h2000, 16'd5, 16'd9, 16'd20, 16'd0, 16'd0);
        send_vertex(pick_vertex(), 1'b0);
        set_frames(16'hc000, 16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd1);
        send_vertex(pick_vertex(), 1'b0);
        set_frames(16'h0000, 16'd1, 16'd0, 16'd65535, 16'd0, 16'd1);
        send_vertex(pick_vertex(), 1'b0);
        set_frames(16'h1000, 16'd65534, 16'd0, 16'd65535, 16'd65535, 16'd65535);
        send_vertex(pick_vertex(), 1'b0);

        // random phases: realistic segments mostly, raw registers sometimes
        for (int ph = 0; ph < 30; ph++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                logic [15:0] sp;
                logic [15:0] ss;
                sp = 16'($urandom_range(1, 12));
                ss = 16'(sp * $urandom_range(0, 8));
                frame = int'(ss) + int'($urandom_range(0, sp));
                set_frames(16'($urandom_range(0, 65535)), 16'(frame), ss, ss + sp,
                           16'(sp * $urandom_range(1, 9)), sp);
            end
            else
                set_frames(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 16'($urandom()), 16'($urandom()));
            for (int n = 0; n < 14; n++)
                send_vertex(pick_vertex(), ($urandom_range(0, 2) != 0) && (ph % 5 != 0));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.mismatches == 0 && board.expected_points.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ keyframe_spline_interpolator_unit.f @@
rtl/kfs_pkg.sv
rtl/kfs_weight_gen.sv
rtl/kfs_lane.sv
rtl/keyframe_spline_interpolator_unit.sv
verif/keyframe_spline_interpolator_unit_tb.sv
